/* sv/klex_pkg.sv */
// Shared types, constants and character classification for the keyword token lexer.
package klex_pkg;

	localparam int MAX_TOKEN_LEN = 256;
	localparam int OFFSET_WIDTH  = 32;
	localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN - 1 < 255) ? (MAX_TOKEN_LEN - 1) : 255;
	localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [4:0] KIND_FUN       = 5'd0;
	localparam logic [4:0] KIND_LET       = 5'd1;
	localparam logic [4:0] KIND_RETURN    = 5'd2;
	localparam logic [4:0] KIND_INT       = 5'd3;
	localparam logic [4:0] KIND_INTDOLLAR = 5'd4;
	localparam logic [4:0] KIND_IDENT     = 5'd5;
	localparam logic [4:0] KIND_INTLIT    = 5'd6;
	localparam logic [4:0] KIND_LPAREN    = 5'd7;
	localparam logic [4:0] KIND_RPAREN    = 5'd8;
	localparam logic [4:0] KIND_LBRACE    = 5'd9;
	localparam logic [4:0] KIND_RBRACE    = 5'd10;
	localparam logic [4:0] KIND_COLON     = 5'd11;
	localparam logic [4:0] KIND_SEMI      = 5'd12;
	localparam logic [4:0] KIND_PLUS      = 5'd13;
	localparam logic [4:0] KIND_MINUS     = 5'd14;
	localparam logic [4:0] KIND_STAR      = 5'd15;
	localparam logic [4:0] KIND_SLASH     = 5'd16;
	localparam logic [4:0] KIND_ASSIGN    = 5'd17;
	localparam logic [4:0] KIND_UNKNOWN   = 5'd18;
	localparam logic [4:0] KIND_EOF       = 5'd19;

	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_UNDER   = 8'h5f;

	localparam int NUM_KW = 5;
	localparam int KW_IDX_INTDOLLAR = 4;
	localparam logic [7:0] KW_LEN_INT = 8'd3;

	localparam logic [7:0] KW_TEXT [NUM_KW][6] = '{
		'{8'h66, 8'h75, 8'h6e, 8'h00, 8'h00, 8'h00},
		'{8'h6c, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
		'{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
		'{8'h69, 8'h6e, 8'h74, 8'h24, 8'h00, 8'h00}
	};
	localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd3, 8'd3, 8'd6, 8'd3, 8'd4};

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_WORD    = 2'd2,
		MODE_NUMBER  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} src_word_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] token_start;
		logic [7:0]  token_length;
		logic [7:0]  unknown_char;
		logic        last_of_run;
	} tok_word_t;

	typedef struct packed {
		logic [1:0] count;
		tok_word_t  w0;
		tok_word_t  w1;
	} push_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	// Keeps each candidate keyword whose character at position i equals c.
	function automatic logic [NUM_KW-1:0] kw_keep(input logic [NUM_KW-1:0] cand,
			input logic [7:0] i, input logic [7:0] c);
		logic [NUM_KW-1:0] keep;
		keep = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (cand[k] && i < KW_LEN[k] && KW_TEXT[k][i[2:0]] == c) begin
				keep[k] = 1'b1;
			end
		end
		return keep;
	endfunction

	function automatic logic [4:0] word_kind(input logic [NUM_KW-1:0] cand,
			input logic [7:0] len);
		logic [4:0] kind;
		kind = KIND_IDENT;
		for (int k = 0; k < KW_IDX_INTDOLLAR; k++) begin
			if (cand[k] && len == KW_LEN[k]) begin
				kind = 5'(k);
			end
		end
		return kind;
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		logic       hit;
		logic [4:0] kind;
		hit  = 1'b1;
		kind = KIND_UNKNOWN;
		unique case (c)
			8'h28: kind = KIND_LPAREN;
			8'h29: kind = KIND_RPAREN;
			8'h7b: kind = KIND_LBRACE;
			8'h7d: kind = KIND_RBRACE;
			8'h3a: kind = KIND_COLON;
			8'h3b: kind = KIND_SEMI;
			8'h2b: kind = KIND_PLUS;
			8'h2d: kind = KIND_MINUS;
			8'h2a: kind = KIND_STAR;
			8'h2f: kind = KIND_SLASH;
			8'h3d: kind = KIND_ASSIGN;
			default: hit = 1'b0;
		endcase
		return {hit, kind};
	endfunction

endpackage

/* sv/klex_scan.sv */
// Scanner state and per-byte classification that produces up to two tokens per byte.
module klex_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  klex_pkg::src_word_t   src_word,
	output klex_pkg::push_t       push
);

	klex_pkg::mode_t                       mode_q, mode_d;
	logic [klex_pkg::OFFSET_WIDTH-1:0]     start_q, start_d;
	logic [klex_pkg::OFFSET_WIDTH-1:0]     pos_q, pos_d;
	logic [7:0]                            len_q, len_d;
	logic [klex_pkg::NUM_KW-1:0]           cand_q, cand_d;

	logic [7:0] c;
	logic       eoi;
	logic       c_letter, c_digit, c_alnum, c_space;
	logic       dollar_hit;
	logic       run_idle;
	logic [5:0] pk;
	logic [7:0] len_grow;

	klex_pkg::tok_word_t tok_a, tok_b;
	logic                a_valid, b_valid;

	assign c          = src_word.char_code;
	assign eoi        = src_word.end_of_input;
	assign c_letter   = klex_pkg::is_letter(c);
	assign c_digit    = klex_pkg::is_digit(c);
	assign c_alnum    = c_letter | c_digit;
	assign c_space    = klex_pkg::is_space(c);
	assign pk         = klex_pkg::punct_kind(c);
	assign len_grow   = (len_q < klex_pkg::LEN_CAP) ? len_q + 8'd1 : len_q;
	assign dollar_hit = c == klex_pkg::CH_DOLLAR && cand_q[klex_pkg::KW_IDX_INTDOLLAR]
		&& len_q == klex_pkg::KW_LEN_INT;

	// The byte is handled from the idle state, after any pending token is flushed.
	always_comb begin
		run_idle = 1'b0;
		unique case (mode_q)
			klex_pkg::MODE_IDLE:    run_idle = 1'b1;
			klex_pkg::MODE_COMMENT: run_idle = 1'b0;
			klex_pkg::MODE_WORD:    run_idle = !c_alnum && !dollar_hit;
			klex_pkg::MODE_NUMBER:  run_idle = !c_digit;
			default:                run_idle = 1'b0;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		cand_d  = cand_q;
		pos_d   = pos_q;
		if (accept) begin
			pos_d = pos_q + 1'b1;
			if (eoi) begin
				mode_d  = klex_pkg::MODE_IDLE;
				start_d = '0;
				len_d   = '0;
				cand_d  = '0;
				pos_d   = '0;
			end else if (mode_q == klex_pkg::MODE_COMMENT) begin
				if (c == klex_pkg::CH_NEWLINE) begin
					mode_d = klex_pkg::MODE_IDLE;
				end
			end else if (mode_q == klex_pkg::MODE_WORD && c_alnum) begin
				cand_d = klex_pkg::kw_keep(cand_q, len_q, c);
				len_d  = len_grow;
			end else if (mode_q == klex_pkg::MODE_NUMBER && c_digit) begin
				len_d = len_grow;
			end else begin
				mode_d = klex_pkg::MODE_IDLE;
				len_d  = '0;
				cand_d = '0;
				if (run_idle) begin
					if (c == klex_pkg::CH_HASH) begin
						mode_d = klex_pkg::MODE_COMMENT;
					end else if (c_letter) begin
						mode_d  = klex_pkg::MODE_WORD;
						start_d = pos_q;
						len_d   = 8'd1;
						cand_d  = klex_pkg::kw_keep('1, 8'd0, c);
					end else if (c_digit) begin
						mode_d  = klex_pkg::MODE_NUMBER;
						start_d = pos_q;
						len_d   = 8'd1;
					end
				end
			end
		end
	end

	always_comb begin
		tok_a              = '0;
		tok_a.token_start  = 32'(start_q);
		tok_a.token_length = len_q;
		tok_a.token_kind   = (mode_q == klex_pkg::MODE_NUMBER) ? klex_pkg::KIND_INTLIT
			: klex_pkg::word_kind(cand_q, len_q);
		if (!eoi && dollar_hit) begin
			tok_a.token_kind   = klex_pkg::KIND_INTDOLLAR;
			tok_a.token_length = 8'd4;
		end
		a_valid = accept && (mode_q == klex_pkg::MODE_WORD || mode_q == klex_pkg::MODE_NUMBER)
			&& (eoi || run_idle || (mode_q == klex_pkg::MODE_WORD && dollar_hit));

		tok_b             = '0;
		tok_b.token_start = 32'(pos_q);
		tok_b.last_of_run = 1'b1;
		if (eoi) begin
			tok_b.token_kind = klex_pkg::KIND_EOF;
		end else if (pk[5]) begin
			tok_b.token_kind   = pk[4:0];
			tok_b.token_length = 8'd1;
		end else begin
			tok_b.token_kind   = klex_pkg::KIND_UNKNOWN;
			tok_b.token_length = 8'd1;
			tok_b.unknown_char = c;
		end
		b_valid = accept && (eoi || (run_idle && !pk[5] == 1'b0) || (run_idle && !(
			c == klex_pkg::CH_HASH || c_space || c_letter || c_digit)));
		tok_a.last_of_run = !b_valid;
	end

	always_comb begin
		push = '0;
		if (a_valid) begin
			push.w0    = tok_a;
			push.w1    = tok_b;
			push.count = b_valid ? 2'd2 : 2'd1;
		end else begin
			push.w0    = tok_b;
			push.w1    = tok_b;
			push.count = b_valid ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= klex_pkg::MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			cand_q  <= '0;
			pos_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			cand_q  <= cand_d;
			pos_q   <= pos_d;
		end
	end

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eoi |=> mode_q == klex_pkg::MODE_IDLE && pos_q == '0 && len_q == '0)
		else $error("End of input did not return the scanner to its reset state.");

	a_comment_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !eoi && mode_q == klex_pkg::MODE_COMMENT |-> push.count == 2'd0)
		else $error("A byte inside a comment produced a token.");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == klex_pkg::MODE_IDLE || mode_q == klex_pkg::MODE_COMMENT
		|-> len_q == '0 && cand_q == '0)
		else $error("Pending token state left behind outside a word or number.");

endmodule

/* sv/klex_outq.sv */
// Small result queue that takes up to two tokens per cycle and delivers one per cycle while the reader is ready.
module klex_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  klex_pkg::push_t      push,
	output logic                 ready,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output klex_pkg::tok_word_t  tok_word
);

	klex_pkg::tok_word_t             mem_q [klex_pkg::OQ_DEPTH];
	logic [klex_pkg::OQ_PTR_W-1:0]   wr_q, rd_q;
	logic [klex_pkg::OQ_CNT_W-1:0]   count_q;
	logic [klex_pkg::OQ_PTR_W-1:0]   wr_next;
	logic                            pop;

	assign ready     = count_q <= klex_pkg::OQ_CNT_W'(klex_pkg::OQ_DEPTH - 2);
	assign tok_valid = count_q != '0;
	assign tok_word  = mem_q[rd_q];
	assign pop       = tok_valid && tok_ready;
	assign wr_next   = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.w0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + klex_pkg::OQ_PTR_W'(push.count);
			rd_q    <= rd_q + klex_pkg::OQ_PTR_W'(pop);
			count_q <= count_q + klex_pkg::OQ_CNT_W'(push.count) - klex_pkg::OQ_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> 32'(count_q) + 32'(push.count) <= klex_pkg::OQ_DEPTH)
		else $error("Result queue overflow.");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> count_q == $past(count_q) - 1'b1)
		else $error("Queue count did not drop after a lone read.");

endmodule

/* sv/keyword_token_lexer.sv */
// Top level of the keyword token lexer: scanner followed by the result queue.
//
// One source byte (or an end-of-input mark) enters per word on the src channel; tokens
// leave on the tok channel as kind, start offset, length, unknown byte and a flag on the
// last token caused by each input word. Both channels use valid/ready.
// An accepted byte updates the scanner state in the same cycle and its tokens (zero, one
// or two) are written to a four-entry queue; the first token is visible on tok once any
// tokens ahead of it have left. One input word is taken per clock as long as the queue
// holds two or fewer entries; the queue drains one token per clock while the receiver
// is ready.
// When the receiver stalls, tokens collect in the queue and src_ready drops once three
// entries are held; no token is lost or reordered.
// Reset clears the scanner to idle with offset zero and empties the queue. An
// end-of-input word flushes any pending word or number, emits EOF and returns the
// scanner to that same reset state, so the next byte starts a new source at offset 0.
module keyword_token_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  klex_pkg::src_word_t  src_word,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output klex_pkg::tok_word_t  tok_word
);

	klex_pkg::push_t push;
	logic            accept;

	assign accept = src_valid && src_ready;

	klex_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.src_word (src_word),
		.push     (push)
	);

	klex_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.ready     (src_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_word  (tok_word)
	);

endmodule

/* bench/tb_keyword_token_lexer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the keyword token lexer with a token predictor and scoreboard.
module tb_keyword_token_lexer;

	localparam int RUN_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 950;

	typedef enum {RX_STEADY, RX_CHOPPY, RX_SLOW} rx_pattern_t;

	class token_scoreboard;
		klex_pkg::tok_word_t expected_tokens[$];
		int errors;
		string kw_text[5];
		string punct_set;
		klex_pkg::mode_t mode;
		logic [31:0] tok_start;
		logic [31:0] next_pos;
		logic [7:0] tok_len;
		logic [4:0] kw_live;
		int produced;

		function new();
			kw_text = '{"fun", "let", "return", "int", "int$"};
			punct_set = "(){}:;+-*/=";
			errors = 0;
			reset_state();
		endfunction

		function void reset_state();
			mode = klex_pkg::MODE_IDLE;
			tok_start = '0;
			next_pos = '0;
			tok_len = '0;
			kw_live = '0;
		endfunction

		function bit ch_letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == klex_pkg::CH_UNDER;
		endfunction

		function bit ch_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit ch_blank(logic [7:0] c);
			return c == " " || (c >= 8'd9 && c <= 8'd13);
		endfunction

		function void emit(logic [4:0] kind, logic [31:0] start, logic [7:0] len,
				logic [7:0] uc);
			klex_pkg::tok_word_t t;
			t.token_kind = kind;
			t.token_start = start;
			t.token_length = len;
			t.unknown_char = uc;
			t.last_of_run = 1'b0;
			expected_tokens.push_back(t);
			produced++;
		endfunction

		function void mark_last();
			if (produced > 0) begin
				expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
			end
		endfunction

		function void lengthen();
			if (tok_len < klex_pkg::LEN_CAP) begin
				tok_len++;
			end
		endfunction

		function void close_pending();
			logic [4:0] kind;
			if (mode == klex_pkg::MODE_WORD) begin
				kind = klex_pkg::KIND_IDENT;
				for (int k = 0; k < 4; k++) begin
					if (kw_live[k] && tok_len == kw_text[k].len()) begin
						kind = 5'(k);
					end
				end
				emit(kind, tok_start, tok_len, 8'd0);
			end else if (mode == klex_pkg::MODE_NUMBER) begin
				emit(klex_pkg::KIND_INTLIT, tok_start, tok_len, 8'd0);
			end
			mode = klex_pkg::MODE_IDLE;
			tok_len = '0;
			kw_live = '0;
		endfunction

		function void start_fresh(logic [7:0] c, logic [31:0] pos);
			if (c == klex_pkg::CH_HASH) begin
				mode = klex_pkg::MODE_COMMENT;
				return;
			end
			if (ch_blank(c)) begin
				return;
			end
			if (ch_letter(c) || ch_digit(c)) begin
				mode = ch_letter(c) ? klex_pkg::MODE_WORD : klex_pkg::MODE_NUMBER;
				tok_start = pos;
				tok_len = 8'd1;
				kw_live = '0;
				if (mode == klex_pkg::MODE_WORD) begin
					for (int k = 0; k < 5; k++) begin
						if (kw_text[k][0] == c) begin
							kw_live[k] = 1'b1;
						end
					end
				end
				return;
			end
			for (int p = 0; p < punct_set.len(); p++) begin
				if (punct_set[p] == c) begin
					emit(klex_pkg::KIND_LPAREN + 5'(p), pos, 8'd1, 8'd0);
					return;
				end
			end
			emit(klex_pkg::KIND_UNKNOWN, pos, 8'd1, c);
		endfunction

		function void note_source(klex_pkg::src_word_t w);
			logic [7:0] c;
			logic [31:0] pos;
			logic [4:0] keep;
			c = w.char_code;
			pos = next_pos;
			produced = 0;
			if (w.end_of_input) begin
				close_pending();
				emit(klex_pkg::KIND_EOF, pos, 8'd0, 8'd0);
				mark_last();
				reset_state();
				return;
			end
			case (mode)
				klex_pkg::MODE_COMMENT: begin
					if (c == klex_pkg::CH_NEWLINE) begin
						mode = klex_pkg::MODE_IDLE;
					end
				end
				klex_pkg::MODE_WORD: begin
					if (ch_letter(c) || ch_digit(c)) begin
						keep = '0;
						for (int k = 0; k < 5; k++) begin
							if (kw_live[k] && tok_len < kw_text[k].len() &&
									kw_text[k][tok_len] == c) begin
								keep[k] = 1'b1;
							end
						end
						kw_live = keep;
						lengthen();
					end else if (c == klex_pkg::CH_DOLLAR &&
							kw_live[klex_pkg::KW_IDX_INTDOLLAR] &&
							tok_len == klex_pkg::KW_LEN_INT) begin
						emit(klex_pkg::KIND_INTDOLLAR, tok_start, 8'd4, 8'd0);
						mode = klex_pkg::MODE_IDLE;
						tok_len = '0;
						kw_live = '0;
					end else begin
						close_pending();
						start_fresh(c, pos);
					end
				end
				klex_pkg::MODE_NUMBER: begin
					if (ch_digit(c)) begin
						lengthen();
					end else begin
						close_pending();
						start_fresh(c, pos);
					end
				end
				default: start_fresh(c, pos);
			endcase
			next_pos = pos + 32'd1;
			mark_last();
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_token(klex_pkg::tok_word_t got);
			klex_pkg::tok_word_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: token mismatch: expected none, actual kind %0d start %0d",
					$time, got.token_kind, got.token_start);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			field_check("token_kind", 32'(want.token_kind), 32'(got.token_kind));
			field_check("token_start", want.token_start, got.token_start);
			field_check("token_length", 32'(want.token_length), 32'(got.token_length));
			field_check("unknown_char", 32'(want.unknown_char), 32'(got.unknown_char));
			field_check("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	klex_pkg::src_word_t src_word = '0;
	logic tok_valid;
	logic tok_ready = 1'b0;
	klex_pkg::tok_word_t tok_word;

	token_scoreboard sb;
	int burst_left = 0;
	int counted_items = 0;
	int unsigned cycle_count = 0;
	rx_pattern_t rx_pattern = RX_STEADY;
	int rx_left = 0;

	keyword_token_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_word(src_word),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_word(tok_word)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_valid && tok_ready) begin
			sb.check_token(tok_word);
		end
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(16, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_pattern)
			RX_STEADY: tok_ready <= 1'b1;
			RX_CHOPPY: tok_ready <= 1'($urandom_range(0, 1));
			default: tok_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_word(input klex_pkg::src_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				src_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		src_valid = 1'b1;
		src_word = w;
		do @(posedge clk); while (!src_ready);
		sb.note_source(w);
		burst_left--;
		counted_items++;
		@(negedge clk);
	endtask

	task automatic send_char(input logic [7:0] c);
		klex_pkg::src_word_t w;
		w.char_code = c;
		w.end_of_input = 1'b0;
		send_word(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	task automatic send_eof();
		klex_pkg::src_word_t w;
		w.char_code = 8'($urandom_range(0, 255));
		w.end_of_input = 1'b1;
		send_word(w);
	endtask

	function automatic logic [7:0] ident_char(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return klex_pkg::CH_UNDER;
		return 8'("0" + r - 53);
	endfunction

	task automatic send_source();
		int pieces;
		int pick;
		int n;
		int r;
		logic [7:0] c;
		string kw;
		pieces = $urandom_range(0, 30);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_text(sb.kw_text[$urandom_range(0, 4)]);
			end else if (pick < 30) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					send_char(ident_char(i == 0));
				end
			end else if (pick < 40) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					send_char(8'("0" + $urandom_range(0, 9)));
				end
			end else if (pick < 55) begin
				send_char(sb.punct_set[$urandom_range(0, 10)]);
			end else if (pick < 68) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(8, 13);
					send_char((r == 8) ? 8'h20 : 8'(r));
				end
			end else if (pick < 76) begin
				send_char(klex_pkg::CH_HASH);
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++) begin
					c = 8'($urandom_range(0, 255));
					send_char((c == klex_pkg::CH_NEWLINE) ? 8'h20 : c);
				end
				if (p != pieces - 1 || $urandom_range(0, 1) == 1) begin
					send_char(klex_pkg::CH_NEWLINE);
				end
			end else if (pick < 82) begin
				send_char(klex_pkg::CH_DOLLAR);
			end else if (pick < 92) begin
				send_char(8'($urandom_range(0, 255)));
			end else begin
				// A keyword prefix, then a dollar, an identifier character or nothing.
				kw = sb.kw_text[$urandom_range(0, 4)];
				send_text(kw.substr(0, $urandom_range(0, kw.len() - 1)));
				r = $urandom_range(0, 2);
				if (r == 0) begin
					send_char(klex_pkg::CH_DOLLAR);
				end else if (r == 1) begin
					send_char(ident_char(1'b0));
				end
			end
		end
		send_eof();
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text("fun(int$x)let:{return 9}+-*/=;");
		send_char(8'h00);
		send_char(8'hff);
		send_text("_Z");
		send_eof();
		send_text("#c");
		send_eof();

		// Words and numbers long enough to saturate the length field.
		send_char(ident_char(1'b1));
		repeat (257) send_char(ident_char(1'b0));
		send_char(" ");
		repeat (258) send_char(8'("0" + $urandom_range(0, 9)));
		send_eof();

		while (counted_items < RANDOM_ITEMS) begin
			send_source();
		end
		src_valid = 1'b0;

		while (sb.expected_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* keyword_token_lexer.f */
sv/klex_pkg.sv
sv/klex_scan.sv
sv/klex_outq.sv
sv/keyword_token_lexer.sv
bench/tb_keyword_token_lexer.sv
